[hw/rtl/brb_pkg.sv]
// Shared types and codes for the batch ring buffer with statistics.
// Holds the transfer payload structs, status and kind codes and counter indexes.
// No dependencies.
`default_nettype none

package brb_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_STAT = 2'd2
  } brb_kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_INVAL = 2'd3
  } brb_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_DEQ
  } brb_state_t;

  localparam int unsigned NUM_STATS    = 9;
  localparam int unsigned CNT_ENQ      = 0;
  localparam int unsigned CNT_DEQ      = 1;
  localparam int unsigned CNT_EMPTY    = 2;
  localparam int unsigned CNT_FULL     = 3;
  localparam int unsigned CNT_INVAL    = 4;
  localparam int unsigned CNT_SPLIT_WR = 5;
  localparam int unsigned CNT_WR       = 6;
  localparam int unsigned CNT_SPLIT_RD = 7;
  localparam int unsigned CNT_RD       = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] push_data;
    logic        batch_last;
    logic [6:0]  request_count;
    logic [3:0]  counter_index;
  } brb_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  done_count;
    logic [31:0] pop_data;
    logic        element_valid;
    logic        run_last;
    logic [31:0] counter_value;
    logic [5:0]  free_slots;
    logic [5:0]  filled_slots;
  } brb_out_t;

endpackage

`default_nettype wire

[hw/rtl/brb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module brb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/batch_ring_buffer_with_stats.sv]
// Top level of the batch ring buffer with saturating statistics counters.
// Depends on brb_pkg and brb_ram.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) carries push elements, dequeue
// requests and counter reads. The result channel (out_valid, out_stall, out_data)
// returns one transfer per result. A run of push items forms a batch; only the
// item marked batch_last gives a result, registered in the cycle after it is accepted.
// Push items and counter reads are taken at one per cycle while no dequeue run
// is in progress and the result register is free or draining. A dequeue of n
// elements reads the ring memory one element per cycle while the receiver does
// not stall: the request loads the read pointer and the run count, then each read
// fills the RAM read data and the result register together until the last element.
// Requests with a single status result give it in the cycle after they are accepted.
// When the receiver stalls, the result register holds its transfer and the
// memory read is paused, so the input is stalled as well.
// Reset clears the indexes, the open batch and all counters; the ring contents
// stay undefined until written.
`default_nettype none

module batch_ring_buffer_with_stats #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned ELEMENT_BITS = 32,
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire brb_pkg::brb_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output brb_pkg::brb_out_t     out_data
);

  import brb_pkg::*;

  localparam int unsigned IDXW = $clog2(SLOTS);
  localparam int unsigned IW1  = IDXW + 1;
  localparam int unsigned RW   = IDXW + 8;
  localparam int unsigned CW1  = COUNTER_BITS + 1;
  localparam logic [IDXW:0] SLOTS_W = IW1'(SLOTS);
  localparam logic [COUNTER_BITS:0] CNT_TOP = {1'b0, {COUNTER_BITS{1'b1}}};

  brb_state_t state_r, state_nxt;

  logic [IDXW-1:0] rd_r, rd_nxt;
  logic [IDXW-1:0] wr_r, wr_nxt;
  logic [IDXW-1:0] stg_r, stg_nxt;
  logic [IDXW-1:0] acc_r, acc_nxt;
  logic            open_r, open_nxt;
  logic            refused_r, refused_nxt;
  logic [IDXW-1:0] rem_r, rem_nxt;
  logic [IDXW-1:0] rptr_r, rptr_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    elem_r, elem_nxt;
  brb_out_t                meta_r, meta_nxt;

  logic [COUNTER_BITS-1:0] cnt_r   [NUM_STATS];
  logic [COUNTER_BITS-1:0] cnt_nxt [NUM_STATS];
  logic [COUNTER_BITS:0]   cnt_sum [NUM_STATS];
  logic [IDXW-1:0]         cnt_amt [NUM_STATS];
  logic [COUNTER_BITS-1:0] cnt_sel;

  logic                    in_acc;
  logic                    ram_re;
  logic                    ram_we;
  logic [IDXW-1:0]         ram_waddr;
  logic [ELEMENT_BITS-1:0] ram_wdata;
  logic [ELEMENT_BITS-1:0] ram_rdata;

  logic                    res_valid;
  logic                    deq_start;
  brb_out_t                res_meta;
  logic                    b_refused;
  logic                    b_store;
  logic [IDXW-1:0]         b_stg;
  logic [IDXW-1:0]         b_acc;
  logic [IDXW-1:0]         b_n;
  logic [IDXW-1:0]         d_filled;
  logic [IDXW-1:0]         d_n;
  logic [IDXW-1:0]         filled_post;

  brb_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (deq_start) begin
          state_nxt = ST_DEQ;
        end
      end
      ST_DEQ: begin
        if (ram_re && (rem_r == IDXW'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
      end
      ST_DEQ: begin
        ram_re = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
        ram_re   = 1'b0;
      end
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < NUM_STATS; i++) begin
      if (in_data.counter_index == 4'(i)) begin
        cnt_sel = cnt_r[i];
      end
    end
  end

  // Item processing on an accepted input transfer.
  always_comb begin
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    stg_nxt     = stg_r;
    acc_nxt     = acc_r;
    open_nxt    = open_r;
    refused_nxt = refused_r;
    ram_we      = 1'b0;
    ram_wdata   = ELEMENT_BITS'(in_data.push_data);
    res_valid   = 1'b0;
    deq_start   = 1'b0;
    res_meta    = '0;
    for (int i = 0; i < NUM_STATS; i++) begin
      cnt_amt[i] = '0;
    end

    b_refused = open_r ? refused_r : ((wr_r + IDXW'(1)) == rd_r);
    b_stg     = open_r ? stg_r : wr_r;
    b_acc     = open_r ? acc_r : '0;
    b_store   = !b_refused && ((b_stg + IDXW'(1)) != rd_r);
    b_n       = b_store ? (b_acc + IDXW'(1)) : b_acc;
    ram_waddr = b_stg;

    d_filled = wr_r - rd_r;
    d_n      = (RW'(in_data.request_count) < RW'(d_filled)) ?
               IDXW'(in_data.request_count) : d_filled;

    if (in_acc) begin
      case (in_data.kind)
        KIND_PUSH: begin
          ram_we  = b_store;
          stg_nxt = b_store ? (b_stg + IDXW'(1)) : b_stg;
          acc_nxt = b_n;
          if (!in_data.batch_last) begin
            open_nxt    = 1'b1;
            refused_nxt = b_refused;
          end else begin
            open_nxt    = 1'b0;
            refused_nxt = 1'b0;
            acc_nxt     = '0;
            res_valid   = 1'b1;
            if (b_refused) begin
              cnt_amt[CNT_FULL] = IDXW'(1);
              res_meta.status   = STAT_FULL;
            end else begin
              if (({1'b0, wr_r} + {1'b0, b_n}) > SLOTS_W) begin
                cnt_amt[CNT_SPLIT_WR] = IDXW'(1);
              end else begin
                cnt_amt[CNT_WR] = IDXW'(1);
              end
              cnt_amt[CNT_ENQ]    = b_n;
              wr_nxt              = stg_nxt;
              res_meta.status     = STAT_OK;
              res_meta.done_count = 6'(b_n);
            end
          end
        end
        KIND_DEQ: begin
          if (RW'(in_data.request_count) > RW'(SLOTS)) begin
            cnt_amt[CNT_INVAL] = IDXW'(1);
            res_valid          = 1'b1;
            res_meta.status    = STAT_INVAL;
          end else if (d_filled == '0) begin
            cnt_amt[CNT_EMPTY] = IDXW'(1);
            res_valid          = 1'b1;
            res_meta.status    = STAT_EMPTY;
          end else begin
            if (({1'b0, rd_r} + {1'b0, d_n}) > SLOTS_W) begin
              cnt_amt[CNT_SPLIT_RD] = IDXW'(1);
            end else begin
              cnt_amt[CNT_RD] = IDXW'(1);
            end
            cnt_amt[CNT_DEQ]    = d_n;
            rd_nxt              = rd_r + d_n;
            res_meta.status     = STAT_OK;
            res_meta.done_count = 6'(d_n);
            if (d_n == '0) begin
              res_valid = 1'b1;
            end else begin
              deq_start = 1'b1;
            end
          end
        end
        KIND_STAT: begin
          res_valid = 1'b1;
          if (in_data.counter_index < 4'(NUM_STATS)) begin
            res_meta.status        = STAT_OK;
            res_meta.counter_value = 32'(cnt_sel);
          end else begin
            res_meta.status = STAT_INVAL;
          end
        end
        default: begin
          res_valid       = 1'b1;
          res_meta.status = STAT_INVAL;
        end
      endcase
    end

    filled_post           = wr_nxt - rd_nxt;
    res_meta.run_last     = 1'b1;
    res_meta.filled_slots = 6'(filled_post);
    res_meta.free_slots   = 6'(~filled_post);
  end

  always_comb begin
    for (int i = 0; i < NUM_STATS; i++) begin
      cnt_sum[i] = CW1'(cnt_r[i]) + CW1'(cnt_amt[i]);
      cnt_nxt[i] = (cnt_sum[i] >= CNT_TOP) ? CNT_TOP[COUNTER_BITS-1:0]
                                           : cnt_sum[i][COUNTER_BITS-1:0];
    end
  end

  // Dequeue read sequencing and the result register.
  always_comb begin
    rem_nxt       = rem_r;
    rptr_nxt      = rptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    elem_nxt      = elem_r;
    meta_nxt      = meta_r;
    if (deq_start) begin
      rem_nxt  = d_n;
      rptr_nxt = rd_r;
      meta_nxt = res_meta;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      elem_nxt      = 1'b0;
      meta_nxt      = res_meta;
    end
    if (ram_re) begin
      rem_nxt           = rem_r - IDXW'(1);
      rptr_nxt          = rptr_r + IDXW'(1);
      out_valid_nxt     = 1'b1;
      elem_nxt          = 1'b1;
      meta_nxt.run_last = (rem_r == IDXW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_r        <= '0;
      wr_r        <= '0;
      stg_r       <= '0;
      acc_r       <= '0;
      open_r      <= 1'b0;
      refused_r   <= 1'b0;
      rem_r       <= '0;
      rptr_r      <= '0;
      out_valid_r <= 1'b0;
      elem_r      <= 1'b0;
      for (int i = 0; i < NUM_STATS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      stg_r       <= stg_nxt;
      acc_r       <= acc_nxt;
      open_r      <= open_nxt;
      refused_r   <= refused_nxt;
      rem_r       <= rem_nxt;
      rptr_r      <= rptr_nxt;
      out_valid_r <= out_valid_nxt;
      elem_r      <= elem_nxt;
      for (int i = 0; i < NUM_STATS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_data = meta_r;
    if (elem_r) begin
      out_data.pop_data      = 32'(ram_rdata);
      out_data.element_valid = 1'b1;
    end else begin
      out_data.pop_data      = '0;
      out_data.element_valid = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_read_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (rem_r != '0))
    else $error("ring read issued with no elements left in the run");

  a_last_read_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && (rem_r == IDXW'(1))) |=>
      ((state_r == ST_IDLE) && out_valid_r && out_data.run_last))
    else $error("final element did not close the dequeue run");

  a_refused_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
    refused_r |-> open_r)
    else $error("refused flag set outside an open batch");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEQ) |-> !ram_we)
    else $error("ring written during a dequeue run");
`endif

endmodule

`default_nettype wire

[tb/brb_ring_checker.sv]
`timescale 1ns / 100ps
// Checker for the batch ring buffer: it watches both transfer channels, keeps its own
// copy of the ring, batch state and statistics, and compares every result transfer.
// Depends on brb_pkg for the payload structs, codes and counter indexes.

module brb_ring_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  brb_pkg::brb_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  brb_pkg::brb_out_t out_data,
  output int                fail_count,
  output int                outstanding
);

  import brb_pkg::*;

  localparam int unsigned RING_SLOTS = 64;
  localparam int unsigned IDX_MASK   = RING_SLOTS - 1;
  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

  logic [31:0]  ring [RING_SLOTS];
  int unsigned  rd_idx;
  int unsigned  wr_idx;
  int unsigned  staged_idx;
  int unsigned  batch_cnt;
  logic         batch_open;
  logic         batch_refused;
  logic [31:0]  stat_cnt [NUM_STATS];
  brb_out_t     due_results [$];
  brb_out_t     head;
  int           mismatches = 0;
  int           owed_now = 0;

  assign fail_count  = mismatches;
  assign outstanding = owed_now;

  function automatic int unsigned ring_fill();
    return (wr_idx - rd_idx) & IDX_MASK;
  endfunction

  task automatic bump(input int unsigned which, input int unsigned amount);
    longint unsigned c;
    c = stat_cnt[which];
    if (amount >= CNT_MAX - c) stat_cnt[which] = CNT_MAX[31:0];
    else stat_cnt[which] = c + amount;
  endtask

  task automatic owe(input brb_status_t st, input int unsigned done, input logic [31:0] data,
                     input logic elem, input logic last, input logic [31:0] cval);
    brb_out_t r;
    int unsigned fill;
    fill = ring_fill();
    r.status        = st;
    r.done_count    = done[5:0];
    r.pop_data      = data;
    r.element_valid = elem;
    r.run_last      = last;
    r.counter_value = cval;
    r.free_slots    = 6'(RING_SLOTS - 1 - fill);
    r.filled_slots  = fill[5:0];
    due_results.push_back(r);
  endtask

  task automatic advance_ring(input brb_in_t it);
    int unsigned req;
    int unsigned fill;
    int unsigned n;
    int unsigned start;
    case (it.kind)
      KIND_PUSH: begin
        if (!batch_open) begin
          batch_open    = 1'b1;
          batch_refused = (((wr_idx + 1) & IDX_MASK) == rd_idx);
          staged_idx    = wr_idx;
          batch_cnt     = 0;
        end
        if (!batch_refused && ((staged_idx + 1) & IDX_MASK) != rd_idx) begin
          ring[staged_idx] = it.push_data;
          staged_idx       = (staged_idx + 1) & IDX_MASK;
          batch_cnt++;
        end
        if (it.batch_last) begin
          if (batch_refused) begin
            bump(CNT_FULL, 1);
            owe(STAT_FULL, 0, '0, 1'b0, 1'b1, '0);
          end else begin
            if (wr_idx + batch_cnt > RING_SLOTS) bump(CNT_SPLIT_WR, 1);
            else bump(CNT_WR, 1);
            wr_idx = staged_idx;
            bump(CNT_ENQ, batch_cnt);
            owe(STAT_OK, batch_cnt, '0, 1'b0, 1'b1, '0);
          end
          batch_open    = 1'b0;
          batch_refused = 1'b0;
          batch_cnt     = 0;
        end
      end
      KIND_DEQ: begin
        req  = it.request_count;
        fill = ring_fill();
        if (req > RING_SLOTS) begin
          bump(CNT_INVAL, 1);
          owe(STAT_INVAL, 0, '0, 1'b0, 1'b1, '0);
        end else if (fill == 0) begin
          bump(CNT_EMPTY, 1);
          owe(STAT_EMPTY, 0, '0, 1'b0, 1'b1, '0);
        end else begin
          n     = (req < fill) ? req : fill;
          start = rd_idx;
          if (start + n > RING_SLOTS) bump(CNT_SPLIT_RD, 1);
          else bump(CNT_RD, 1);
          rd_idx = (start + n) & IDX_MASK;
          bump(CNT_DEQ, n);
          if (n == 0) owe(STAT_OK, 0, '0, 1'b0, 1'b1, '0);
          for (int unsigned i = 0; i < n; i++)
            owe(STAT_OK, n, ring[(start + i) & IDX_MASK], 1'b1, i + 1 == n, '0);
        end
      end
      KIND_STAT: begin
        if (it.counter_index < NUM_STATS)
          owe(STAT_OK, 0, '0, 1'b0, 1'b1, stat_cnt[it.counter_index]);
        else
          owe(STAT_INVAL, 0, '0, 1'b0, 1'b1, '0);
      end
      default: owe(STAT_INVAL, 0, '0, 1'b0, 1'b1, '0);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rd_idx        = 0;
      wr_idx        = 0;
      staged_idx    = 0;
      batch_cnt     = 0;
      batch_open    = 1'b0;
      batch_refused = 1'b0;
      for (int i = 0; i < NUM_STATS; i++) stat_cnt[i] = '0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) advance_ring(in_data);
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("Result transfer arrived with no result outstanding.");
          mismatches++;
        end else begin
          head = due_results.pop_front();
          check_field("status", head.status, out_data.status);
          check_field("done_count", head.done_count, out_data.done_count);
          check_field("pop_data", head.pop_data, out_data.pop_data);
          check_field("element_valid", head.element_valid, out_data.element_valid);
          check_field("run_last", head.run_last, out_data.run_last);
          check_field("counter_value", head.counter_value, out_data.counter_value);
          check_field("free_slots", head.free_slots, out_data.free_slots);
          check_field("filled_slots", head.filled_slots, out_data.filled_slots);
        end
      end
    end
    owed_now <= due_results.size();
  end

endmodule

[tb/batch_ring_buffer_with_stats_tb.sv]
`timescale 1ns / 100ps
// Top of the batch ring buffer testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on brb_pkg, batch_ring_buffer_with_stats and brb_ring_checker.

module batch_ring_buffer_with_stats_tb;
  import brb_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  brb_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  brb_out_t out_data;
  int       fail_count;
  int       outstanding;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  int       hold_reqs = 0;
  int       holds_done = 0;
  int       sent;
  int       len;
  int       phase_pct [4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{30, 30}};

  always #1 clk = ~clk;

  batch_ring_buffer_with_stats u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  brb_ring_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send(input logic [1:0] kind, input logic [31:0] data, input logic last,
                      input logic [6:0] req, input logic [3:0] idx);
    brb_in_t it;
    it.kind          = kind;
    it.push_data     = data;
    it.batch_last    = last;
    it.request_count = req;
    it.counter_index = idx;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic push_batch(input int n);
    for (int i = 0; i < n; i++)
      send(KIND_PUSH, $urandom, i == n - 1, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send(KIND_DEQ, $urandom, $urandom, 7'd1, $urandom);
    send(KIND_DEQ, $urandom, $urandom, 7'd65, $urandom);
    send(KIND_DEQ, $urandom, $urandom, 7'd127, $urandom);
    send(KIND_STAT, $urandom, $urandom, $urandom, 4'd15);
    send(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
    send(KIND_PUSH, 32'h0000_0000, 1'b0, $urandom, $urandom);
    send(KIND_PUSH, 32'hFFFF_FFFF, 1'b0, $urandom, $urandom);
    send(KIND_PUSH, 32'hA5A5_5A5A, 1'b1, $urandom, $urandom);
    send(KIND_DEQ, $urandom, $urandom, 7'd0, $urandom);
    send(KIND_PUSH, $urandom, 1'b0, $urandom, $urandom);
    send(KIND_DEQ, $urandom, $urandom, 7'd2, $urandom);
    send(KIND_STAT, $urandom, $urandom, $urandom, 4'd8);
    send(KIND_PUSH, $urandom, 1'b1, $urandom, $urandom);
    send(KIND_DEQ, $urandom, $urandom, 7'd64, $urandom);
    send(KIND_DEQ, $urandom, $urandom, 7'd0, $urandom);
    send(KIND_STAT, $urandom, $urandom, $urandom, 4'd9);

    // Hold the receiver off while a batch overfills the ring and a second batch is refused.
    drain();
    hold_reqs++;
    push_batch(66);
    push_batch(2);
    send(KIND_DEQ, $urandom, $urandom, 7'd64, $urandom);
    for (int i = 0; i < 16; i++) send(KIND_STAT, $urandom, $urandom, $urandom, 4'(i));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = phase_pct[ph][0];
      rx_stall_pct = phase_pct[ph][1];
      sent = 0;
      while (sent < 28) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            len = ($urandom_range(15) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
            push_batch(len);
            sent += len;
          end
          9, 10, 11, 12, 13: begin
            if ($urandom_range(7) == 0)
              send(KIND_DEQ, $urandom, $urandom, $urandom_range(65, 127), $urandom);
            else
              send(KIND_DEQ, $urandom, $urandom, $urandom_range(0, 64), $urandom);
            sent++;
          end
          14, 15: begin
            send(KIND_STAT, $urandom, $urandom, $urandom, $urandom_range(15));
            sent++;
          end
          16: begin
            send(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
            sent++;
          end
          17, 18: begin
            send(KIND_PUSH, $urandom, 1'b0, $urandom, $urandom);
            send(KIND_DEQ, $urandom, $urandom, $urandom_range(0, 8), $urandom);
            send(KIND_STAT, $urandom, $urandom, $urandom, $urandom_range(15));
            send(KIND_PUSH, $urandom, 1'b1, $urandom, $urandom);
            sent += 4;
          end
          default: begin
            send($urandom, $urandom, $urandom, $urandom, $urandom);
            sent++;
          end
        endcase
      end
    end

    push_batch(1);
    drain();
    rx_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("batch_ring_buffer_with_stats verification clean");
    else
      $display("batch_ring_buffer_with_stats verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("batch_ring_buffer_with_stats verification failed");
    $finish;
  end

endmodule

[batch_ring_buffer_with_stats.f]
hw/rtl/brb_pkg.sv
hw/rtl/brb_ram.sv
hw/rtl/batch_ring_buffer_with_stats.sv
tb/brb_ring_checker.sv
tb/batch_ring_buffer_with_stats_tb.sv
